/* rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file of the hex flag command line parser.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is active.
`define HFCL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hfcl assertion failed");

// Clocked check that also holds during reset.
`define HFCL_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hfcl reset assertion failed");

`else

`define HFCL_ASSERT(lbl, clk, rst_n, prop)
`define HFCL_ASSERT_RST(lbl, clk, prop)

`endif

`endif

/* rtl/hfcl_pkg.sv */
// Package of the hex flag command line parser: sizes, character codes, types
// and the hex digit decoder. Depends on nothing.
package hfcl_pkg;

    // Sizes
    localparam int LINE_DEPTH  = 32;
    localparam int FLAG_BITS   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CHAR_W      = 8;
    localparam int OUT_W       = 32;
    localparam int EV_W        = 3;
    localparam int CFG_W       = 32;
    localparam int PADDR_W     = 2;
    localparam int IDX_W       = $clog2(LINE_DEPTH);
    localparam int FILL_W      = $clog2(LINE_DEPTH + 1);
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SET = 8'd61;
    localparam logic [CHAR_W-1:0] CH_ADD = 8'd43;
    localparam logic [CHAR_W-1:0] CH_CLR = 8'd45;

    // Register addresses
    localparam logic [PADDR_W-1:0] REG_INITIAL_FLAGS = 2'd0;

    // Result event codes
    typedef enum logic [EV_W-1:0] {
        EV_STORED  = 3'd0,
        EV_FULL    = 3'd1,
        EV_BACK    = 3'd2,
        EV_EMPTY   = 3'd3,
        EV_SET     = 3'd4,
        EV_ADDED   = 3'd5,
        EV_REMOVED = 3'd6,
        EV_INVALID = 3'd7
    } t_event;

    // Character classes found by the front end
    typedef enum logic [1:0] {
        K_STORE,
        K_BACK,
        K_END
    } t_kind;

    // Action chosen by the line prefix
    typedef enum logic [1:0] {
        ACT_SET,
        ACT_ADD,
        ACT_CLR
    } t_act;

    // Back end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One classified command in the queue
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] code;
    } t_cmd;

    // Decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decodes an ASCII hex digit in either case.
    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            h.val = 4'(c - 8'd48);
        end else if (c >= 8'd97 && c <= 8'd102) begin
            h.val = 4'(c - 8'd87);
        end else if (c >= 8'd65 && c <= 8'd70) begin
            h.val = 4'(c - 8'd55);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* rtl/hfcl_if.sv */
// Handshake channel interfaces of the hex flag command line parser.
// Depends on hfcl_pkg for the payload widths.
interface hfcl_char_if;
    logic                          valid;
    logic                          ready;
    logic [hfcl_pkg::CHAR_W-1:0]   char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface hfcl_res_if;
    logic                          valid;
    logic                          ready;
    logic [hfcl_pkg::OUT_W-1:0]    flags_value;
    logic [hfcl_pkg::OUT_W-1:0]    line_mask;
    logic [hfcl_pkg::EV_W-1:0]     event_res;

    modport source (output valid, output flags_value, output line_mask, output event_res,
                    input ready);
    modport sink   (input valid, input flags_value, input line_mask, input event_res,
                    output ready);
endinterface

/* rtl/hex_flag_command_line_parser.sv */
// Top level of the hex flag command line parser: front end, queue, back end
// and the APB register. Depends on hfcl_pkg, hfcl_if and assert_macros.svh.
//
// Usage: console characters arrive on i_char, one per beat. Each accepted
// character yields exactly one result beat on o_res with the flags register,
// the parsed line mask and an event code. A carriage return ends the line:
// an optional '=', '+' or '-' prefix picks set, OR-in or clear, and the rest
// must be hex digits. The APB register initial_flags at address 0 reloads
// the flags and empties the line when written; write it only while idle.
// An ordinary character or backspace passes through the queue entry and the
// output register. A line end with stored characters runs a scan that reads
// the line store one entry per cycle through its single read port and stops
// at the end of the line or at the first character that is not a hex digit.
// A two entry queue sits between classification and execution, so input
// beats are still taken while the back end scans or the output stalls.
// When o_res.ready is low the result stays in the output register and the
// back end waits; the queue then fills and i_char.ready drops.
// Reset clears the line, the flags and initial_flags to zero.
`include "assert_macros.svh"

module hex_flag_command_line_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hfcl_char_if.sink                       i_char,
    hfcl_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hfcl_pkg::PADDR_W-1:0]    paddr,
    input  logic [hfcl_pkg::CFG_W-1:0]      pwdata,
    output logic [hfcl_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);
    import hfcl_pkg::*;

    logic              w_push_valid;
    logic              w_push_ready;
    t_cmd              w_push_data;
    logic              w_pop_valid;
    logic              w_pop_ready;
    t_cmd              w_pop_data;
    logic              w_cfg_wr;
    logic [CFG_W-1:0]  r_initial_flags;
    logic              w_char_beat;
    logic              w_no_mask_ev;

    // APB register port; the single register decodes at every address.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_flags <= '0;
        end else if (w_cfg_wr) begin
            r_initial_flags <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr)
            REG_INITIAL_FLAGS: prdata = r_initial_flags;
            default:           prdata = r_initial_flags;
        endcase
    end

    // Classification front end.
    hfcl_front u_front (
        .i_char       (i_char),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // Command queue.
    hfcl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Execution back end.
    hfcl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_data  (pwdata),
        .o_res       (o_res)
    );

    // Terms used by the checks below.
    assign w_char_beat  = i_char.valid && i_char.ready;
    assign w_no_mask_ev = (o_res.event_res == EV_STORED) || (o_res.event_res == EV_FULL) ||
                          (o_res.event_res == EV_BACK) || (o_res.event_res == EV_EMPTY) ||
                          (o_res.event_res == EV_INVALID);

    // Checks on the block's own sequencing.
    `HFCL_ASSERT_RST(a_rst_no_result, i_clk, !i_rst_n |=> !o_res.valid)
    `HFCL_ASSERT(a_mask_zero, i_clk, i_rst_n, (o_res.valid && w_no_mask_ev) |-> (o_res.line_mask == '0))
    `HFCL_ASSERT(a_queue_stays_empty, i_clk, i_rst_n, (!w_pop_valid && !w_char_beat) |=> !w_pop_valid)

endmodule

/* rtl/hfcl_front.sv */
// Front end: accepts console characters and classifies them into commands.
// Depends on hfcl_pkg and hfcl_char_if.
module hfcl_front (
    hfcl_char_if.sink          i_char,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output hfcl_pkg::t_cmd     o_push_data
);
    import hfcl_pkg::*;

    // A beat moves straight into the queue when it has room.
    assign o_push_valid   = i_char.valid;
    assign i_char.ready   = i_push_ready;

    // Sort the character into line end, backspace or ordinary character.
    always_comb begin
        o_push_data.code = i_char.char_code;
        priority if (i_char.char_code == CH_CR) begin
            o_push_data.kind = K_END;
        end else if (i_char.char_code == CH_BS) begin
            o_push_data.kind = K_BACK;
        end else begin
            o_push_data.kind = K_STORE;
        end
    end

endmodule

/* rtl/hfcl_queue.sv */
// Short command queue between the front end and the back end.
// Depends on hfcl_pkg.
module hfcl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  hfcl_pkg::t_cmd     i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output hfcl_pkg::t_cmd     o_pop_data
);
    import hfcl_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/hfcl_back.sv */
// Back end: line store, fill count, flags register and the line end scan.
// Depends on hfcl_pkg and hfcl_res_if.
module hfcl_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pop_valid,
    output logic                         o_pop_ready,
    input  hfcl_pkg::t_cmd               i_pop_data,
    input  logic                         i_cfg_wr,
    input  logic [hfcl_pkg::CFG_W-1:0]   i_cfg_data,
    hfcl_res_if.source                   o_res
);
    import hfcl_pkg::*;

    // Line store memory
    logic [CHAR_W-1:0]    r_line [LINE_DEPTH];
    logic [CHAR_W-1:0]    r_rd_data;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_mem_we;

    // Control and datapath registers
    t_state               r_state, n_state;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [FLAG_BITS-1:0] r_flags, n_flags;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [FLAG_BITS-1:0] r_mask, n_mask;
    logic                 r_bad, n_bad;
    t_act                 r_act, n_act;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_flags, n_out_flags;
    logic [OUT_W-1:0]     r_out_mask, n_out_mask;
    t_event               r_out_ev, n_out_ev;

    logic                 w_slot_free;
    logic                 w_pop;
    logic                 w_scan_done;
    logic                 w_is_prefix;
    logic [FLAG_BITS-1:0] w_new_flags;
    t_hex                 w_hex;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign o_pop_ready = (r_state == S_IDLE) && w_slot_free;
    assign w_pop       = i_pop_valid && o_pop_ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.flags_value = r_out_flags;
    assign o_res.line_mask   = r_out_mask;
    assign o_res.event_res   = r_out_ev;

    // Scan step: decode the stored character read out for this index.
    assign w_hex       = hex_decode(r_rd_data);
    assign w_is_prefix = (r_idx == '0) &&
                         (r_rd_data == CH_SET || r_rd_data == CH_ADD || r_rd_data == CH_CLR);
    assign w_scan_done = (!w_is_prefix && !w_hex.ok) ||
                         ((FILL_W'(r_idx) + 1'b1) == r_fill);

    // Flags after a valid line.
    always_comb begin
        unique case (r_act)
            ACT_ADD: w_new_flags = r_flags | r_mask;
            ACT_CLR: w_new_flags = r_flags & ~r_mask;
            default: w_new_flags = r_mask;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop && i_pop_data.kind == K_END && r_fill != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result values for each state.
    always_comb begin
        n_fill      = r_fill;
        n_flags     = r_flags;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_bad       = r_bad;
        n_act       = r_act;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_flags = r_out_flags;
        n_out_mask  = r_out_mask;
        n_out_ev    = r_out_ev;
        w_mem_we    = 1'b0;
        w_rd_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    n_out_flags = OUT_W'(r_flags);
                    n_out_mask  = '0;
                    unique case (i_pop_data.kind)
                        K_END: begin
                            if (r_fill == '0) begin
                                n_out_valid = 1'b1;
                                n_out_ev    = EV_EMPTY;
                            end else begin
                                n_idx  = '0;
                                n_mask = '0;
                                n_bad  = 1'b0;
                                n_act  = ACT_SET;
                            end
                        end
                        K_BACK: begin
                            n_out_valid = 1'b1;
                            n_out_ev    = EV_BACK;
                            if (r_fill != '0) begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            if (r_fill < FILL_W'(LINE_DEPTH)) begin
                                w_mem_we = 1'b1;
                                n_fill   = r_fill + 1'b1;
                                n_out_ev = EV_STORED;
                            end else begin
                                n_out_ev = EV_FULL;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_rd_addr = r_idx + 1'b1;
                n_idx     = r_idx + 1'b1;
                if (w_is_prefix) begin
                    if (r_rd_data == CH_ADD) begin
                        n_act = ACT_ADD;
                    end else if (r_rd_data == CH_CLR) begin
                        n_act = ACT_CLR;
                    end else begin
                        n_act = ACT_SET;
                    end
                end else if (!w_hex.ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_mask = FLAG_BITS'({r_mask, w_hex.val});
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_fill      = '0;
                    if (r_bad) begin
                        n_out_flags = OUT_W'(r_flags);
                        n_out_mask  = '0;
                        n_out_ev    = EV_INVALID;
                    end else begin
                        n_flags     = w_new_flags;
                        n_out_flags = OUT_W'(w_new_flags);
                        n_out_mask  = OUT_W'(r_mask);
                        unique case (r_act)
                            ACT_ADD: n_out_ev = EV_ADDED;
                            ACT_CLR: n_out_ev = EV_REMOVED;
                            default: n_out_ev = EV_SET;
                        endcase
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        // A register write reloads the flags and empties the line.
        if (i_cfg_wr) begin
            n_flags = FLAG_BITS'(i_cfg_data);
            n_fill  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_mask      <= n_mask;
        r_bad       <= n_bad;
        r_act       <= n_act;
        r_out_flags <= n_out_flags;
        r_out_mask  <= n_out_mask;
        r_out_ev    <= n_out_ev;
    end

    // Line store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line[r_fill[IDX_W-1:0]] <= i_pop_data.code;
        end
        r_rd_data <= r_line[w_rd_addr];
    end

endmodule

/* tb/hfcl_line_checker.sv */
// Scoreboard for the hex flag command line parser: watches the character,
// result and APB ports, predicts every result beat and compares it.
// Depends on hfcl_pkg and the channel interfaces in hfcl_if.
module hfcl_line_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hfcl_char_if                            i_char,
    hfcl_res_if                             i_res,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [hfcl_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [hfcl_pkg::CFG_W-1:0]      i_pwdata,
    input  logic [hfcl_pkg::CFG_W-1:0]      i_prdata,
    input  logic                            i_pready,
    output int                              o_errors,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hfcl_pkg::*;

    localparam int MAX_PRINTED = 40;

    localparam logic [CHAR_W-1:0] ASC_0  = "0";
    localparam logic [CHAR_W-1:0] ASC_9  = "9";
    localparam logic [CHAR_W-1:0] ASC_LA = "a";
    localparam logic [CHAR_W-1:0] ASC_LF = "f";
    localparam logic [CHAR_W-1:0] ASC_UA = "A";
    localparam logic [CHAR_W-1:0] ASC_UF = "F";

    // One predicted result beat.
    typedef struct packed {
        logic [OUT_W-1:0] flags;
        logic [OUT_W-1:0] mask;
        t_event           ev;
    } t_line_result;

    // Shadow copy of the parser state.
    logic [CHAR_W-1:0]    line_buf [LINE_DEPTH];
    int unsigned          line_fill;
    logic [FLAG_BITS-1:0] flags_now;
    logic [CFG_W-1:0]     flags_init;
    t_line_result         expected_q [$];

    // Value of a hex digit in either case, or -1 for any other byte.
    function automatic int hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= ASC_0 && c <= ASC_9) begin
            return int'(c - ASC_0);
        end
        if (c >= ASC_LA && c <= ASC_LF) begin
            return int'(c - ASC_LA) + 10;
        end
        if (c >= ASC_UA && c <= ASC_UF) begin
            return int'(c - ASC_UA) + 10;
        end
        return -1;
    endfunction

    // Applies one character to the shadow state and returns its result.
    function automatic t_line_result apply_char(input logic [CHAR_W-1:0] c);
        t_line_result         r;
        t_act                 act;
        int unsigned          pos;
        int                   d;
        logic                 bad;
        logic [FLAG_BITS-1:0] mask;
        mask = '0;
        r.ev = EV_STORED;
        if (c == CH_CR) begin
            if (line_fill == 0) begin
                r.ev = EV_EMPTY;
            end else begin
                act = ACT_SET;
                pos = 0;
                bad = 1'b0;
                // A leading prefix picks the action; without one the line sets.
                if (line_buf[0] == CH_ADD) begin
                    act = ACT_ADD;
                    pos = 1;
                end else if (line_buf[0] == CH_CLR) begin
                    act = ACT_CLR;
                    pos = 1;
                end else if (line_buf[0] == CH_SET) begin
                    pos = 1;
                end
                // Digits shift in from the right; overflow falls off the top.
                for (int unsigned i = pos; i < line_fill && !bad; i++) begin
                    d = hex_digit(line_buf[i]);
                    if (d < 0) begin
                        bad = 1'b1;
                    end else begin
                        mask = {mask[FLAG_BITS-5:0], 4'(d)};
                    end
                end
                if (bad) begin
                    mask = '0;
                    r.ev = EV_INVALID;
                end else begin
                    case (act)
                        ACT_ADD: begin
                            flags_now = flags_now | mask;
                            r.ev = EV_ADDED;
                        end
                        ACT_CLR: begin
                            flags_now = flags_now & ~mask;
                            r.ev = EV_REMOVED;
                        end
                        default: begin
                            flags_now = mask;
                            r.ev = EV_SET;
                        end
                    endcase
                end
            end
            line_fill = 0;
        end else if (c == CH_BS) begin
            if (line_fill > 0) begin
                line_fill--;
            end
            r.ev = EV_BACK;
        end else if (line_fill < LINE_DEPTH) begin
            line_buf[line_fill] = c;
            line_fill++;
        end else begin
            r.ev = EV_FULL;
        end
        r.flags = OUT_W'(flags_now);
        r.mask  = OUT_W'(mask);
        return r;
    endfunction

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (o_errors < MAX_PRINTED) begin
            $display("%0t: mismatch: %s", $time, what);
        end
        o_errors++;
    endtask

    // Sample all ports on the rising edge, before the block updates them.
    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            foreach (line_buf[i]) begin
                line_buf[i] = '0;
            end
            line_fill  = 0;
            flags_now  = '0;
            flags_init = '0;
            expected_q.delete();
            o_errors   = 0;
        end else begin
            // Register write: reloads the flags and empties the line.
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == REG_INITIAL_FLAGS) begin
                flags_init = i_pwdata;
                flags_now  = FLAG_BITS'(i_pwdata);
                line_fill  = 0;
            end
            // Register read-back.
            if (i_psel && i_penable && !i_pwrite && i_pready &&
                i_paddr == REG_INITIAL_FLAGS && i_prdata != flags_init) begin
                report_mismatch($sformatf("initial_flags read %h, written %h",
                                          i_prdata, flags_init));
            end
            // Result beat against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending, event %0d",
                                              i_res.event_res));
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.flags_value != want.flags) begin
                        report_mismatch($sformatf("flags_value %h, predicted %h",
                                                  i_res.flags_value, want.flags));
                    end
                    if (i_res.line_mask != want.mask) begin
                        report_mismatch($sformatf("line_mask %h, predicted %h",
                                                  i_res.line_mask, want.mask));
                    end
                    if (i_res.event_res != want.ev) begin
                        report_mismatch($sformatf("event_res %0d, predicted %s",
                                                  i_res.event_res, want.ev.name()));
                    end
                end
            end
            // Character beat: predict its result.
            if (i_char.valid && i_char.ready) begin
                expected_q.push_back(apply_char(i_char.char_code));
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

/* tb/tb_hex_flag_command_line_parser.sv */
// Top of the hex flag command line parser testbench: clock, reset, character
// and APB stimulus, receiver stalls, watchdog and verdict.
// Depends on hfcl_pkg, hfcl_if, the parser RTL and hfcl_line_checker.
module tb_hex_flag_command_line_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hfcl_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int QUIET_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 117;

    localparam logic [CHAR_W-1:0] ASC_0  = "0";
    localparam logic [CHAR_W-1:0] ASC_LA = "a";
    localparam logic [CHAR_W-1:0] ASC_UA = "A";

    typedef logic [CHAR_W-1:0] t_bytes [$];

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    int idle_in_pct;
    int idle_out_pct;
    int items_sent;
    int quiet_cycles;
    int error_count;
    int outstanding;

    hfcl_char_if char_bus ();
    hfcl_res_if  res_bus ();

    hex_flag_command_line_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hfcl_line_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char        (char_bus),
        .i_res         (res_bus),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (error_count),
        .o_outstanding (outstanding)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Receiver stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        res_bus.ready = ($urandom_range(99) >= idle_out_pct);
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_bus.valid && char_bus.ready) ||
            (res_bus.valid && res_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_hex_flag_command_line_parser: done, errors");
                $finish;
            end
        end
    end

    // Random hex digit, either case.
    function automatic logic [CHAR_W-1:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) begin
            return CHAR_W'(ASC_0 + v);
        end
        if ($urandom_range(1) == 1) begin
            return CHAR_W'(ASC_LA + v - 10);
        end
        return CHAR_W'(ASC_UA + v - 10);
    endfunction

    // Random byte that is neither a hex digit nor a line control.
    function automatic logic [CHAR_W-1:0] rand_bad_char();
        int v;
        do begin
            v = $urandom_range(255);
        end while (v inside {[48:57], [65:70], [97:102], CH_CR, CH_BS});
        return CHAR_W'(v);
    endfunction

    // Random action prefix, or none.
    function automatic void push_prefix(ref t_bytes line);
        case ($urandom_range(3))
            1: line.push_back(CH_SET);
            2: line.push_back(CH_ADD);
            3: line.push_back(CH_CLR);
            default: ;
        endcase
    endfunction

    // Sends one character beat; returns right after the edge that takes it.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_in_pct) begin
            char_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid     = 1'b1;
        char_bus.char_code = c;
        do begin
            @(posedge i_clk);
        end while (!char_bus.ready);
        items_sent++;
    endtask

    task automatic send_bytes(input t_bytes line);
        foreach (line[i]) begin
            send_char(line[i]);
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        char_bus.valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = REG_INITIAL_FLAGS;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Writes initial_flags while the parser is idle, then reads it back.
    task automatic set_initial_flags(input logic [CFG_W-1:0] value);
        drain_results();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    // One random line: mostly well-formed commands, the rest broken or noise.
    task automatic send_random_line();
        t_bytes line;
        int     kind;
        int     n;
        int     pos;
        kind = $urandom_range(99);
        if (kind < 65) begin
            // Well-formed command, sometimes overflowing or with a typo fixed.
            push_prefix(line);
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            repeat (n) line.push_back(rand_hex_char());
            if ($urandom_range(9) == 0) begin
                pos = $urandom_range(line.size());
                line.insert(pos, CH_BS);
                line.insert(pos, CHAR_W'($urandom_range(255)));
            end
            line.push_back(CH_CR);
        end else if (kind < 75) begin
            // Command with one bad byte somewhere.
            push_prefix(line);
            repeat ($urandom_range(0, 6)) line.push_back(rand_hex_char());
            line.insert($urandom_range(line.size()), rand_bad_char());
            line.push_back(CH_CR);
        end else if (kind < 83) begin
            // Overlong line: the tail is dropped once the store is full.
            push_prefix(line);
            repeat ($urandom_range(LINE_DEPTH, LINE_DEPTH + 8)) line.push_back(rand_hex_char());
            if ($urandom_range(3) == 0) begin
                line.push_back(CH_BS);
            end
            line.push_back(CH_CR);
        end else if (kind < 90) begin
            // Backspaces, often more of them than the characters before them.
            repeat ($urandom_range(0, 3)) line.push_back(rand_hex_char());
            repeat ($urandom_range(1, 5)) line.push_back(CH_BS);
            repeat ($urandom_range(0, 3)) line.push_back(rand_hex_char());
            line.push_back(CH_CR);
        end else begin
            // Raw noise, usually with no line end.
            repeat ($urandom_range(1, 6)) line.push_back(CHAR_W'($urandom_range(255)));
        end
        send_bytes(line);
    endtask

    // Main sequence.
    initial begin
        t_bytes          seq;
        logic [CFG_W-1:0] flags_cfg;
        int              random_start;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        res_bus.ready      = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_rst_n            = 1'b0;
        idle_in_pct        = 25;
        idle_out_pct       = 65;
        items_sent         = 0;
        quiet_cycles       = 0;
        // Hold reset over RESET_CYCLES rising edges, then release it on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty line on reset flags, then each action and corner case.
        send_char(CH_CR);
        set_initial_flags(32'hFFFF_FFFF);
        seq = {CH_BS,                                         // backspace on empty line
               CH_ADD, CH_CR,                                 // prefix only, OR-in zero
               CH_CLR, 8'("f"), 8'("A"), CH_CR,               // clear bits
               8'("1"), 8'("g"), CH_CR,                       // invalid digit
               8'hFF, 8'h00, CH_CR,                           // byte extremes, invalid
               8'("E"), 8'("7"), CH_CR,                       // set without prefix
               CH_SET, CH_CR,                                 // set to zero
               8'("5"), CH_BS, 8'("c"), CH_CR,                // backspace mid-line
               CH_CR};                                        // empty line
        send_bytes(seq);

        // Random phases, each under its own initial_flags; pairs of phases share a stall pattern.
        random_start = items_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    idle_in_pct  = 25;
                    idle_out_pct = 65;
                end
                1: begin
                    idle_in_pct  = 65;
                    idle_out_pct = 25;
                end
                default: begin
                    idle_in_pct  = 0;
                    idle_out_pct = 0;
                end
            endcase
            case (phase)
                0: flags_cfg = 32'h0000_0000;
                1: flags_cfg = 32'hFFFF_FFFF;
                3: flags_cfg = 32'h8000_0001;
                default: flags_cfg = $urandom;
            endcase
            set_initial_flags(flags_cfg);
            while (items_sent < random_start + (phase + 1) * ITEMS_PER_PHASE) begin
                send_random_line();
                if ($urandom_range(39) == 0) begin
                    drain_results();
                end
            end
            // Leave a line half typed after odd phases; the register write that opens the next phase discards it.
            if (phase % 2 == 1) begin
                seq = {CH_ADD, rand_hex_char()};
                send_bytes(seq);
            end
        end

        drain_results();
        if (error_count == 0 && outstanding == 0) begin
            $display("tb_hex_flag_command_line_parser: done, clean");
        end else begin
            $display("tb_hex_flag_command_line_parser: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hfcl_pkg.sv
rtl/hfcl_if.sv
rtl/hfcl_front.sv
rtl/hfcl_queue.sv
rtl/hfcl_back.sv
rtl/hex_flag_command_line_parser.sv
tb/hfcl_line_checker.sv
tb/tb_hex_flag_command_line_parser.sv
